// ----- src/htpc_pkg.sv -----
// Shared types, constants and helper functions for the hex TLV profile parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package htpc_pkg;

    // Expected record lengths, in bytes and in hex characters
    localparam int ICCID_BYTES    = 10;
    localparam int IMSI_BYTES     = 9;
    localparam int KEY_BYTES      = 16;
    localparam int SMSP_HEX_CHARS = 104;

    localparam logic [7:0] ICCID_CHARS = 8'(ICCID_BYTES * 2);
    localparam logic [7:0] IMSI_CHARS  = 8'(IMSI_BYTES * 2);
    localparam logic [7:0] KEY_CHARS   = 8'(KEY_BYTES * 2);
    localparam logic [7:0] SMSP_CHARS  = 8'(SMSP_HEX_CHARS);

    // CRC-32 (reflected IEEE)
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Length of the trailer delay line in characters
    localparam int DLY_DEPTH = 8;
    localparam logic [3:0] DLY_FULL = 4'(DLY_DEPTH);

    // Output queue depth in results
    localparam int QDEPTH = 4;

    // Record kinds
    localparam logic [2:0] KIND_ICCID = 3'd0;
    localparam logic [2:0] KIND_IMSI  = 3'd1;
    localparam logic [2:0] KIND_OPC   = 3'd2;
    localparam logic [2:0] KIND_KI    = 3'd3;
    localparam logic [2:0] KIND_KIC   = 3'd4;
    localparam logic [2:0] KIND_KID   = 3'd5;
    localparam logic [2:0] KIND_SMSP  = 3'd6;
    localparam logic [2:0] KIND_SKIP  = 3'd7;

    // Result kinds
    localparam logic RES_VALUE  = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_TAG_HI = 3'd0,
        PH_TAG_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_VAL_HI = 3'd4,
        PH_VAL_LO = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        CFG_TAG_ICCID = 3'd0,
        CFG_TAG_IMSI  = 3'd1,
        CFG_TAG_OPC   = 3'd2,
        CFG_TAG_KI    = 3'd3,
        CFG_TAG_KIC   = 3'd4,
        CFG_TAG_KID   = 3'd5,
        CFG_TAG_SMSP  = 3'd6,
        CFG_TAG_END   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] tag_iccid;
        logic [7:0] tag_imsi;
        logic [7:0] tag_opc;
        logic [7:0] tag_ki;
        logic [7:0] tag_kic;
        logic [7:0] tag_kid;
        logic [7:0] tag_smsp;
        logic [7:0] tag_end;
    } tags_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] record_kind;
        logic [6:0] byte_index;
        logic [7:0] value_byte;
        logic       length_error;
        logic       end_tag_seen;
        logic       crc_checked;
        logic       crc_match;
        logic       too_short;
        logic       last_of_run;
    } out_item_t;

    // Results produced by one request: count (0..2), then the items in order
    typedef struct packed {
        logic [1:0] num;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    // Hex nibble rule (c % 32 + 9) % 25
    function automatic logic [4:0] nib(input logic [7:0] c);
        logic [5:0] s;
        s = {1'b0, c[4:0]} + 6'd9;
        return (s >= 6'd25) ? 5'(s - 6'd25) : s[4:0];
    endfunction

    // Byte from two nibbles, truncated to 8 bits
    function automatic logic [7:0] pair(input logic [4:0] hi, input logic [4:0] lo);
        return {hi[3:0], 4'b0000} + {3'b000, lo};
    endfunction

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'd0, d};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- src/htpc_cfg.sv -----
// Tag code registers with their write decode.
// Depends on htpc_pkg for the register index codes and the tag bundle type.
`timescale 1ns / 1ps

module htpc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  htpc_pkg::cfg_idx_t  cfg_index,
    input  logic [7:0]          cfg_data,
    output htpc_pkg::tags_t     tags
);
    import htpc_pkg::*;

    tags_t tags_reg;
    tags_t tags_next;

    // Decode the register index
    always_comb
    begin
        tags_next = tags_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAG_ICCID: tags_next.tag_iccid = cfg_data;
                CFG_TAG_IMSI:  tags_next.tag_imsi  = cfg_data;
                CFG_TAG_OPC:   tags_next.tag_opc   = cfg_data;
                CFG_TAG_KI:    tags_next.tag_ki    = cfg_data;
                CFG_TAG_KIC:   tags_next.tag_kic   = cfg_data;
                CFG_TAG_KID:   tags_next.tag_kid   = cfg_data;
                CFG_TAG_SMSP:  tags_next.tag_smsp  = cfg_data;
                CFG_TAG_END:   tags_next.tag_end   = cfg_data;
                default:       tags_next = tags_reg;
            endcase
        end
    end

    // Hold the tag codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.tag_iccid <= 8'd1;
            tags_reg.tag_imsi  <= 8'd2;
            tags_reg.tag_opc   <= 8'd3;
            tags_reg.tag_ki    <= 8'd4;
            tags_reg.tag_kic   <= 8'd5;
            tags_reg.tag_kid   <= 8'd6;
            tags_reg.tag_smsp  <= 8'd7;
            tags_reg.tag_end   <= 8'd255;
        end
        else
        begin
            tags_reg <= tags_next;
        end
    end

    assign tags = tags_reg;

endmodule

// ----- src/htpc_parser.sv -----
// Parse state, CRC path and result formation for one character per cycle while accept is high.
// Depends on htpc_pkg for the phase type, tag bundle, item types and helpers.
`timescale 1ns / 1ps

module htpc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  htpc_pkg::in_item_t  item,
    input  htpc_pkg::tags_t     tags,
    output htpc_pkg::push_t     push
);
    import htpc_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  tag_reg,     tag_next;
    logic [7:0]  rem_reg,     rem_next;
    logic [4:0]  hn_reg,      hn_next;
    logic [2:0]  kind_reg,    kind_next;
    logic [6:0]  idx_reg,     idx_next;
    logic [31:0] crc_reg,     crc_next;
    logic [7:0]  dly_reg      [DLY_DEPTH];
    logic [7:0]  dly_next     [DLY_DEPTH];
    logic [3:0]  seen_reg,    seen_next;
    logic        crcreq_reg,  crcreq_next;
    logic        lenerr_reg,  lenerr_next;
    logic        endseen_reg, endseen_next;

    logic [4:0]  c_nib;
    logic [7:0]  pair_val;
    logic [7:0]  expect_len;
    logic        known;
    logic        value_out;
    logic        full;
    logic [31:0] trailer;
    out_item_t   val_item;
    out_item_t   stat_item;

    assign c_nib    = nib(item.char_in);
    assign pair_val = pair(hn_reg, c_nib);

    // Advance the parse state for one character
    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        rem_next     = rem_reg;
        hn_next      = hn_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        crcreq_next  = crcreq_reg;
        lenerr_next  = lenerr_reg;
        endseen_next = endseen_reg;
        expect_len   = 8'd0;
        known        = 1'b0;
        value_out    = 1'b0;

        unique case (phase_reg)
            PH_TAG_HI:
            begin
                hn_next    = c_nib;
                phase_next = PH_TAG_LO;
            end
            PH_TAG_LO:
            begin
                tag_next   = pair_val;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                hn_next    = c_nib;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                idx_next = 7'd0;
                rem_next = pair_val;
                known    = 1'b1;
                if (tag_reg == tags.tag_iccid)
                begin
                    kind_next  = KIND_ICCID;
                    expect_len = ICCID_CHARS;
                end
                else if (tag_reg == tags.tag_imsi)
                begin
                    kind_next  = KIND_IMSI;
                    expect_len = IMSI_CHARS;
                end
                else if (tag_reg == tags.tag_opc)
                begin
                    kind_next  = KIND_OPC;
                    expect_len = KEY_CHARS;
                end
                else if (tag_reg == tags.tag_ki)
                begin
                    kind_next  = KIND_KI;
                    expect_len = KEY_CHARS;
                end
                else if (tag_reg == tags.tag_kic)
                begin
                    kind_next  = KIND_KIC;
                    expect_len = KEY_CHARS;
                end
                else if (tag_reg == tags.tag_kid)
                begin
                    kind_next  = KIND_KID;
                    expect_len = KEY_CHARS;
                end
                else if (tag_reg == tags.tag_smsp)
                begin
                    kind_next  = KIND_SMSP;
                    expect_len = SMSP_CHARS;
                end
                else if (tag_reg == tags.tag_end)
                begin
                    known = 1'b0;
                end
                else
                begin
                    known       = 1'b0;
                    kind_next   = KIND_SKIP;
                    crcreq_next = 1'b1;
                end

                if (known && (pair_val != expect_len))
                begin
                    lenerr_next = 1'b1;
                end

                // End tag stops parsing; kind stays as it was
                if ((tag_reg == tags.tag_end) && !known)
                begin
                    endseen_next = 1'b1;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    phase_next = (pair_val != 8'd0) ? PH_VAL_HI : PH_TAG_HI;
                end
            end
            PH_VAL_HI:
            begin
                if (rem_reg <= 8'd1)
                begin
                    rem_next   = 8'd0;
                    phase_next = PH_TAG_HI;
                end
                else
                begin
                    hn_next    = c_nib;
                    rem_next   = rem_reg - 8'd1;
                    phase_next = PH_VAL_LO;
                end
            end
            PH_VAL_LO:
            begin
                if (rem_reg != 8'd0)
                begin
                    rem_next = rem_reg - 8'd1;
                end
                if (kind_reg != KIND_SKIP)
                begin
                    value_out = 1'b1;
                    idx_next  = idx_reg + 7'd1;
                end
                phase_next = (rem_next != 8'd0) ? PH_VAL_HI : PH_TAG_HI;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Shift the trailer delay line and feed the CRC with the oldest character
    always_comb
    begin
        for (int i = 0; i < DLY_DEPTH - 1; i++)
        begin
            dly_next[i] = dly_reg[i + 1];
        end
        dly_next[DLY_DEPTH - 1] = item.char_in;
        crc_next  = (seen_reg >= DLY_FULL) ? crc32_byte(crc_reg, dly_reg[0]) : crc_reg;
        seen_next = (seen_reg < DLY_FULL) ? (seen_reg + 4'd1) : seen_reg;
    end

    // Read the trailer as big-endian hex
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            trailer[31 - 8 * i -: 8] = pair(nib(dly_next[2 * i]), nib(dly_next[2 * i + 1]));
        end
    end

    assign full = (seen_next >= DLY_FULL);

    // Form the value and status results
    always_comb
    begin
        val_item             = '0;
        val_item.result_kind = RES_VALUE;
        val_item.record_kind = kind_reg;
        val_item.byte_index  = idx_reg;
        val_item.value_byte  = pair_val;
        val_item.last_of_run = !item.is_last;

        stat_item              = '0;
        stat_item.result_kind  = RES_STATUS;
        stat_item.length_error = lenerr_next;
        stat_item.end_tag_seen = endseen_next;
        stat_item.crc_checked  = crcreq_next;
        stat_item.crc_match    = crcreq_next && full && ((~crc_next) == trailer);
        stat_item.too_short    = crcreq_next && !full;
        stat_item.last_of_run  = 1'b1;

        push = '0;
        if (accept)
        begin
            if (value_out && item.is_last)
            begin
                push.num   = 2'd2;
                push.item0 = val_item;
                push.item1 = stat_item;
            end
            else if (value_out)
            begin
                push.num   = 2'd1;
                push.item0 = val_item;
            end
            else if (item.is_last)
            begin
                push.num   = 2'd1;
                push.item0 = stat_item;
            end
        end
    end

    // Update state on each request; return to reset after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG_HI;
            tag_reg     <= 8'd0;
            rem_reg     <= 8'd0;
            hn_reg      <= 5'd0;
            kind_reg    <= 3'd0;
            idx_reg     <= 7'd0;
            crc_reg     <= CRC_INIT;
            seen_reg    <= 4'd0;
            crcreq_reg  <= 1'b0;
            lenerr_reg  <= 1'b0;
            endseen_reg <= 1'b0;
            for (int i = 0; i < DLY_DEPTH; i++)
            begin
                dly_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            if (item.is_last)
            begin
                phase_reg   <= PH_TAG_HI;
                tag_reg     <= 8'd0;
                rem_reg     <= 8'd0;
                hn_reg      <= 5'd0;
                kind_reg    <= 3'd0;
                idx_reg     <= 7'd0;
                crc_reg     <= CRC_INIT;
                seen_reg    <= 4'd0;
                crcreq_reg  <= 1'b0;
                lenerr_reg  <= 1'b0;
                endseen_reg <= 1'b0;
                for (int i = 0; i < DLY_DEPTH; i++)
                begin
                    dly_reg[i] <= 8'd0;
                end
            end
            else
            begin
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                rem_reg     <= rem_next;
                hn_reg      <= hn_next;
                kind_reg    <= kind_next;
                idx_reg     <= idx_next;
                crc_reg     <= crc_next;
                seen_reg    <= seen_next;
                crcreq_reg  <= crcreq_next;
                lenerr_reg  <= lenerr_next;
                endseen_reg <= endseen_next;
                for (int i = 0; i < DLY_DEPTH; i++)
                begin
                    dly_reg[i] <= dly_next[i];
                end
            end
        end
    end

    // A status result comes only with the last character
    a_two_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> item.is_last)
        else $error("two results from a character that is not the last");

    // The last character restarts parsing from a clean state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.is_last) |=> ((phase_reg == PH_TAG_HI) && (crc_reg == CRC_INIT)
            && (seen_reg == 4'd0)))
        else $error("state not cleared after the last character");

    // The delay line count saturates at its depth
    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= DLY_FULL)
        else $error("character count beyond delay line depth");

endmodule

// ----- src/htpc_out_queue.sv -----
// Result queue: takes up to two results per cycle and hands out one per cycle while out_stall is low.
// Depends on htpc_pkg for the result item and push bundle types.
`timescale 1ns / 1ps

module htpc_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  htpc_pkg::push_t      push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output htpc_pkg::out_item_t  out_data
);
    import htpc_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    out_item_t     mem_reg [QDEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    // Leave space for the two results of one request
    assign room      = (cnt_reg <= (PW + 1)'(QDEPTH - 2));

    // Advance pointers and count
    always_comb
    begin
        wr_next  = wr_reg + PW'(push.num);
        rd_next  = pop ? (rd_reg + PW'(1)) : rd_reg;
        cnt_next = cnt_reg + (PW + 1)'(push.num) - (PW + 1)'(pop);
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_reg] <= push.item0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_reg + PW'(1)] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Never hold more than the queue depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW + 1)'(QDEPTH))
        else $error("result queue overflow");

    // A push arrives only when space was reserved
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> room)
        else $error("push without room");

    // Of two results in one push only the second closes the run
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (push.item1.last_of_run && !push.item0.last_of_run))
        else $error("result pair in wrong order");

endmodule

// ----- src/hex_tlv_profile_parser_crc32_unit.sv -----
// Hex TLV profile parser with CRC-32 trailer check, top level.
// Throughput: one character per cycle while in_stall is low; the last
// character of a profile can yield two results, which leave the four-entry
// result queue one per cycle while out_stall is low. Reset: asynchronous,
// active low; tag codes return to their defaults and the parser to the start
// of a profile. Depends on htpc_pkg and the htpc modules.
`timescale 1ns / 1ps

module hex_tlv_profile_parser_crc32_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  htpc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output htpc_pkg::out_item_t  out_data
);
    import htpc_pkg::*;

    tags_t tags;
    push_t push;
    logic  room;
    logic  accept;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    htpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .tags      (tags)
    );

    htpc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .tags   (tags),
        .push   (push)
    );

    htpc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the hex TLV profile parser with CRC-32 trailer check.
// Feeds directed and random profiles, predicts results with its own parser model.
// Depends on htpc_pkg and the hex_tlv_profile_parser_crc32_unit RTL.
`timescale 1ns / 1ps

module tb;
    import htpc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_CAP   = 100;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = CFG_TAG_ICCID;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;

    hex_tlv_profile_parser_crc32_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Characters waiting to be sent, parser results waiting to arrive
    in_item_t   profile_chars_due[$];
    out_item_t  results_due[$];
    logic [7:0] profile_text[$];

    // Tag codes as currently programmed
    tags_t tag_cfg = {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd255};

    // Parser model state
    phase_t      parse_at;
    logic [7:0]  rec_tag;
    logic [7:0]  rec_left;
    logic [4:0]  hi_digit;
    logic [2:0]  rec_kind;
    logic [6:0]  rec_index;
    logic [31:0] crc_acc;
    logic [7:0]  tail_chars [8];
    logic [3:0]  tail_count;
    logic        crc_wanted;
    logic        len_bad;
    logic        end_hit;

    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    bit   hold_enable    = 1'b0;
    bit   hold_done      = 1'b0;
    logic in_taken       = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Hex digit rule: (c % 32 + 9) % 25
    function automatic logic [4:0] nibble_of(logic [7:0] c);
        return 5'((int'(c) % 32 + 9) % 25);
    endfunction

    function automatic logic [7:0] join_nibbles(logic [4:0] hi, logic [4:0] lo);
        return 8'(int'(hi) * 16 + int'(lo));
    endfunction

    function automatic logic [31:0] crc32_update(logic [31:0] acc, logic [7:0] d);
        logic [31:0] v;
        v = acc ^ {24'h0, d};
        repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic logic [7:0] chars_for_kind(logic [2:0] k);
        case (k)
            KIND_ICCID: return ICCID_CHARS;
            KIND_IMSI:  return IMSI_CHARS;
            KIND_SMSP:  return SMSP_CHARS;
            default:    return KEY_CHARS;
        endcase
    endfunction

    function automatic logic [7:0] tag_of_kind(logic [2:0] k);
        case (k)
            KIND_ICCID: return tag_cfg.tag_iccid;
            KIND_IMSI:  return tag_cfg.tag_imsi;
            KIND_OPC:   return tag_cfg.tag_opc;
            KIND_KI:    return tag_cfg.tag_ki;
            KIND_KIC:   return tag_cfg.tag_kic;
            KIND_KID:   return tag_cfg.tag_kid;
            default:    return tag_cfg.tag_smsp;
        endcase
    endfunction

    function automatic void restart_profile();
        parse_at   = PH_TAG_HI;
        rec_tag    = '0;
        rec_left   = '0;
        hi_digit   = '0;
        rec_kind   = '0;
        rec_index  = '0;
        crc_acc    = CRC_INIT;
        tail_count = '0;
        crc_wanted = 1'b0;
        len_bad    = 1'b0;
        end_hit    = 1'b0;
        foreach (tail_chars[i]) tail_chars[i] = 8'h00;
    endfunction

    // Advance the parser model by one character and queue what it yields
    task automatic parse_profile_char(logic [7:0] c, logic last);
        out_item_t   made[$];
        out_item_t   r;
        logic [7:0]  len;
        logic [31:0] trailer;
        int          i;
        // CRC sees a character once it drops out of the trailer window
        if (tail_count >= 4'd8)
            crc_acc = crc32_update(crc_acc, tail_chars[0]);
        for (i = 0; i < 7; i++)
            tail_chars[i] = tail_chars[i + 1];
        tail_chars[7] = c;
        if (tail_count < 4'd8)
            tail_count++;

        case (parse_at)
            PH_TAG_HI:
            begin
                hi_digit = nibble_of(c);
                parse_at = PH_TAG_LO;
            end
            PH_TAG_LO:
            begin
                rec_tag  = join_nibbles(hi_digit, nibble_of(c));
                parse_at = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                hi_digit = nibble_of(c);
                parse_at = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len       = join_nibbles(hi_digit, nibble_of(c));
                rec_index = '0;
                rec_left  = len;
                parse_at  = (len != 8'd0) ? PH_VAL_HI : PH_TAG_HI;
                // First matching tag wins
                if (rec_tag == tag_cfg.tag_iccid)      rec_kind = KIND_ICCID;
                else if (rec_tag == tag_cfg.tag_imsi)  rec_kind = KIND_IMSI;
                else if (rec_tag == tag_cfg.tag_opc)   rec_kind = KIND_OPC;
                else if (rec_tag == tag_cfg.tag_ki)    rec_kind = KIND_KI;
                else if (rec_tag == tag_cfg.tag_kic)   rec_kind = KIND_KIC;
                else if (rec_tag == tag_cfg.tag_kid)   rec_kind = KIND_KID;
                else if (rec_tag == tag_cfg.tag_smsp)  rec_kind = KIND_SMSP;
                else if (rec_tag == tag_cfg.tag_end)
                begin
                    end_hit  = 1'b1;
                    parse_at = PH_DONE;
                end
                else
                begin
                    rec_kind   = KIND_SKIP;
                    crc_wanted = 1'b1;
                end
                if (parse_at != PH_DONE && rec_kind != KIND_SKIP &&
                    len != chars_for_kind(rec_kind))
                    len_bad = 1'b1;
            end
            PH_VAL_HI:
            begin
                // Drop an unpaired final character
                if (rec_left <= 8'd1)
                begin
                    rec_left = '0;
                    parse_at = PH_TAG_HI;
                end
                else
                begin
                    hi_digit = nibble_of(c);
                    rec_left--;
                    parse_at = PH_VAL_LO;
                end
            end
            PH_VAL_LO:
            begin
                if (rec_left != 8'd0)
                    rec_left--;
                if (rec_kind != KIND_SKIP)
                begin
                    r             = '0;
                    r.result_kind = RES_VALUE;
                    r.record_kind = rec_kind;
                    r.byte_index  = rec_index;
                    r.value_byte  = join_nibbles(hi_digit, nibble_of(c));
                    made.push_back(r);
                    rec_index++;
                end
                parse_at = (rec_left != 8'd0) ? PH_VAL_HI : PH_TAG_HI;
            end
            default: ;
        endcase

        // End of profile: read the trailer big-endian and report status
        if (last)
        begin
            trailer = '0;
            for (i = 0; i < 4; i++)
                trailer = {trailer[23:0],
                           join_nibbles(nibble_of(tail_chars[2 * i]),
                                        nibble_of(tail_chars[2 * i + 1]))};
            r              = '0;
            r.result_kind  = RES_STATUS;
            r.length_error = len_bad;
            r.end_tag_seen = end_hit;
            r.crc_checked  = crc_wanted;
            r.crc_match    = crc_wanted && tail_count >= 4'd8 && ((~crc_acc) == trailer);
            r.too_short    = crc_wanted && tail_count < 4'd8;
            made.push_back(r);
            restart_profile();
        end

        if (made.size() > 0)
            made[made.size() - 1].last_of_run = 1'b1;
        foreach (made[k])
            results_due.push_back(made[k]);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch("unexpected result", got.value_byte, 8'h00);
        end
        else
        begin
            want = results_due.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch("result_kind", 8'(got.result_kind), 8'(want.result_kind));
            if (got.record_kind !== want.record_kind)
                report_mismatch("record_kind", 8'(got.record_kind), 8'(want.record_kind));
            if (got.byte_index !== want.byte_index)
                report_mismatch("byte_index", 8'(got.byte_index), 8'(want.byte_index));
            if (got.value_byte !== want.value_byte)
                report_mismatch("value_byte", got.value_byte, want.value_byte);
            if (got.length_error !== want.length_error)
                report_mismatch("length_error", 8'(got.length_error),
                                8'(want.length_error));
            if (got.end_tag_seen !== want.end_tag_seen)
                report_mismatch("end_tag_seen", 8'(got.end_tag_seen),
                                8'(want.end_tag_seen));
            if (got.crc_checked !== want.crc_checked)
                report_mismatch("crc_checked", 8'(got.crc_checked), 8'(want.crc_checked));
            if (got.crc_match !== want.crc_match)
                report_mismatch("crc_match", 8'(got.crc_match), 8'(want.crc_match));
            if (got.too_short !== want.too_short)
                report_mismatch("too_short", 8'(got.too_short), 8'(want.too_short));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
        end
    endtask

    // Profile text builders

    // Pick one of the character codes that decode to nibble n
    function automatic logic [7:0] hex_char(logic [3:0] n);
        int r;
        r = (n >= 4'd9 && $urandom_range(1) == 1) ? int'(n) - 9 : int'(n) + 16;
        return 8'(r + 32 * $urandom_range(7));
    endfunction

    function automatic void append_text(string s);
        foreach (s[i])
            profile_text.push_back(s[i]);
    endfunction

    function automatic void add_hex_byte(logic [7:0] b);
        profile_text.push_back(hex_char(b[7:4]));
        profile_text.push_back(hex_char(b[3:0]));
    endfunction

    function automatic void add_record(logic [7:0] tag, logic [7:0] len);
        add_hex_byte(tag);
        add_hex_byte(len);
        // Mostly hex digits, now and then any byte at all
        repeat (len)
            profile_text.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                            : hex_char(4'($urandom)));
    endfunction

    // Append CRC of the text so far as eight hex characters, or a random value
    function automatic void add_trailer(bit good);
        logic [31:0] acc;
        acc = CRC_INIT;
        foreach (profile_text[i])
            acc = crc32_update(acc, profile_text[i]);
        acc = good ? ~acc : $urandom;
        add_hex_byte(acc[31:24]);
        add_hex_byte(acc[23:16]);
        add_hex_byte(acc[15:8]);
        add_hex_byte(acc[7:0]);
    endfunction

    function automatic logic [7:0] unknown_tag();
        logic [7:0] t;
        bit         clash;
        int         i;
        do
        begin
            t     = 8'($urandom);
            clash = 1'b0;
            for (i = 0; i < 8; i++)
                if (tag_cfg[i * 8 +: 8] == t)
                    clash = 1'b1;
        end
        while (clash);
        return t;
    endfunction

    function automatic logic [7:0] pick_len(logic [2:0] k);
        int         p;
        logic [7:0] want;
        want = chars_for_kind(k);
        p    = $urandom_range(99);
        if (p < 72) return want;
        if (p < 77) return 8'd0;
        if (p < 82) return 8'd1;
        if (p < 91) return p[0] ? want + 8'($urandom_range(1, 3))
                                : want - 8'($urandom_range(1, 2));
        if (p < 97) return 8'($urandom_range(2, 40));
        return 8'($urandom_range(130, 255));
    endfunction

    // Move the built text to the send queue, flagging its final character
    function automatic void emit_profile();
        in_item_t it;
        foreach (profile_text[i])
        begin
            it.char_in = profile_text[i];
            it.is_last = (i == profile_text.size() - 1);
            profile_chars_due.push_back(it);
        end
        profile_text.delete();
    endfunction

    function automatic int build_profile();
        int nrec;
        int skip_slot;
        int pick;
        int k;
        int n;
        bit stopped;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // Noise
            repeat ($urandom_range(1, 30)) profile_text.push_back(8'($urandom));
        end
        else if (pick < 12)
        begin
            // Check requested but too few characters for a trailer
            add_record(unknown_tag(), 8'($urandom_range(0, 2)));
        end
        else
        begin
            nrec      = $urandom_range(1, 4);
            skip_slot = ($urandom_range(99) < 65) ? $urandom_range(0, nrec - 1) : -1;
            stopped   = 1'b0;
            for (k = 0; k < nrec && !stopped; k++)
            begin
                if (k == skip_slot)
                    add_record(unknown_tag(), 8'($urandom_range(0, 20)));
                pick = $urandom_range(99);
                if (pick < 86)
                begin
                    n = $urandom_range(6);
                    if (n == 6 && $urandom_range(2) != 0)
                        n = $urandom_range(5);
                    add_record(tag_of_kind(3'(n)), pick_len(3'(n)));
                end
                else if (pick < 93)
                begin
                    add_record(unknown_tag(), 8'($urandom_range(0, 20)));
                end
                else
                begin
                    // End tag, then a few characters the parser ignores
                    add_hex_byte(tag_cfg.tag_end);
                    add_hex_byte(8'($urandom));
                    repeat ($urandom_range(0, 6)) profile_text.push_back(8'($urandom));
                    stopped = 1'b1;
                end
            end
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                // Cut the profile off inside a record
                add_hex_byte(tag_of_kind(3'($urandom_range(6))));
                add_hex_byte(8'd40);
                repeat ($urandom_range(0, 12)) profile_text.push_back(hex_char(4'($urandom)));
            end
            else if (pick < 85)
                add_trailer(1'b1);
            else if (pick < 95)
                add_trailer(1'b0);
        end
        n = profile_text.size();
        emit_profile();
        return n;
    endfunction

    function automatic void fill_random(int count);
        int sent;
        sent = 0;
        while (sent < count)
            sent += build_profile();
    endfunction

    // Hold until every request is taken and every result has arrived
    task automatic wait_idle();
        do @(posedge clk);
        while (profile_chars_due.size() != 0 || in_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tag(cfg_idx_t which, logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= v;
    endtask

    task automatic program_tags(tags_t t);
        write_tag(CFG_TAG_ICCID, t.tag_iccid);
        write_tag(CFG_TAG_IMSI,  t.tag_imsi);
        write_tag(CFG_TAG_OPC,   t.tag_opc);
        write_tag(CFG_TAG_KI,    t.tag_ki);
        write_tag(CFG_TAG_KIC,   t.tag_kic);
        write_tag(CFG_TAG_KID,   t.tag_kid);
        write_tag(CFG_TAG_SMSP,  t.tag_smsp);
        write_tag(CFG_TAG_END,   t.tag_end);
        @(negedge clk);
        cfg_we  <= 1'b0;
        tag_cfg = t;
    endtask

    // Sequence the test phases
    initial begin
        restart_profile();
        send_idle_pct = 12;
        recv_idle_pct = 78;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One-character profile with the largest character code
        profile_text.push_back(8'hFF);
        emit_profile();
        // Odd-length card identifier, end tag, then an ignored character
        append_text("0103FF");
        profile_text.push_back(8'h00);
        append_text("FF00");
        profile_text.push_back(8'h4F);
        emit_profile();
        // Unknown tag with zero length and a correct trailer
        append_text("0800");
        add_trailer(1'b1);
        emit_profile();

        fill_random(300);
        wait_idle();

        program_tags({$urandom, $urandom});
        fill_random(300);
        wait_idle();

        // Extreme codes, with a duplicate so the earlier register wins
        send_idle_pct = 78;
        recv_idle_pct = 12;
        program_tags({8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h10});
        fill_random(300);
        wait_idle();

        // No idling; the receiver holds off once for a long stretch
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_enable   = 1'b1;
        program_tags({$urandom, $urandom});
        fill_random(300);
        wait_idle();

        program_tags({8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd255});
        fill_random(200);
        wait_idle();

        if (results_due.size() != 0)
            report_mismatch("results never delivered", 8'(results_due.size()), 8'h00);
        if (mismatch_count == 0)
            $display("hex_tlv_profile_parser_crc32_unit regression: pass");
        else
            $display("hex_tlv_profile_parser_crc32_unit regression: fail");
        $finish;
    end

    // Offer the next character once the current request is taken
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (profile_chars_due.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= profile_chars_due.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall results at random, or hold off for a long stretch once
    always @(negedge clk) begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_enable && !hold_done && profile_chars_due.size() > 40)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Predict on accepted requests, then check accepted results
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            parse_profile_char(in_data.char_in, in_data.is_last);
        if (rst_n && out_valid && !out_stall)
            check_result(out_data);
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit %0d reached, %0d results outstanding",
                     CYCLE_LIMIT, results_due.size());
            $display("hex_tlv_profile_parser_crc32_unit regression: fail");
            $finish;
        end
    end

endmodule
